// ===== design/tepq_pkg.sv =====
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared codes and types of the timed event priority queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

  // request opcodes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  // response status codes
  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // sorted insert of the broadcast event
    logic ext;  // shift the whole row one cell toward the head
  } cell_op_t;

endpackage

// ===== design/tepq_req_if.sv =====
// ----------------------------------------------------------------------------
// tepq_req_if
// Request channel: valid/ready handshake with opcode and event payload.
// ----------------------------------------------------------------------------
interface tepq_req_if #(
  parameter int TIME_BITS = 31,
  parameter int TGT_BITS  = 4
) ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [TIME_BITS-1:0] event_time;
  logic                 event_kind;
  logic [TGT_BITS-1:0]  target_index;

  modport source (
    output valid, opcode, event_time, event_kind, target_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, event_time, event_kind, target_index,
    output ready
  );
endinterface

// ===== design/tepq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tepq_rsp_if
// Response channel: valid/ready handshake with status, event and occupancy.
// ----------------------------------------------------------------------------
interface tepq_rsp_if #(
  parameter int TIME_BITS = 31,
  parameter int TGT_BITS  = 4,
  parameter int OCC_BITS  = 7
) ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [TIME_BITS-1:0] out_time;
  logic                 out_kind;
  logic [TGT_BITS-1:0]  out_target;
  logic [OCC_BITS-1:0]  occupancy;

  modport source (
    output valid, status, out_time, out_kind, out_target, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, out_time, out_kind, out_target, occupancy,
    output ready
  );
endinterface

// ===== design/timed_event_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timed_event_priority_queue_unit
// Stable min-priority queue of timed events built as a row of sorted cells.
//
//   channel | dir | fields
//   req_i   | in  | opcode, event_time, event_kind, target_index
//   rsp_o   | out | status, out_time, out_kind, out_target, occupancy
//
// One transaction per cycle while rsp_o does not stall: every cell compares
// against the broadcast event in parallel and the whole row shifts at once,
// so each response sits in the registered output in the cycle after acceptance.
// Reset clears the fill count and the output valid; slot contents stay.
// req_i.ready drops only while a response is held by a stalled rsp_o.
// ----------------------------------------------------------------------------
module timed_event_priority_queue_unit #(
  parameter int DEPTH        = 64,
  parameter int TIME_BITS    = 31,
  parameter int TARGET_COUNT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tepq_req_if.sink   req_i,
  tepq_rsp_if.source rsp_o
);
  import tepq_pkg::*;

  localparam int TGT_BITS = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             is_full, is_empty;
  cell_op_t         op;

  logic [DEPTH-1:0]     place;
  logic [TIME_BITS-1:0] c_time [DEPTH];
  logic                 c_kind [DEPTH];
  logic [TGT_BITS-1:0]  c_tgt  [DEPTH];

  logic                 rsp_valid_q;
  logic [1:0]           status_q, status_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 kind_q, kind_d;
  logic [TGT_BITS-1:0]  tgt_q, tgt_d;
  logic [CNT_W-1:0]     occ_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_full     = (count_q == CNT_W'(DEPTH));
  assign is_empty    = (count_q == '0);

  assign op.ins = accept && (req_i.opcode == OP_INSERT) && !is_full;
  assign op.ext = accept && (req_i.opcode == OP_EXTRACT) && !is_empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                 lp;
      logic [TIME_BITS-1:0] lt, rt;
      logic                 lk, rk;
      logic [TGT_BITS-1:0]  lg, rg;

      if (gi == 0) begin : g_head
        assign lp = 1'b0;
        assign lt = '0;
        assign lk = 1'b0;
        assign lg = '0;
      end else begin : g_mid
        assign lp = place[gi-1];
        assign lt = c_time[gi-1];
        assign lk = c_kind[gi-1];
        assign lg = c_tgt[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign rt = '0;
        assign rk = 1'b0;
        assign rg = '0;
      end else begin : g_body
        assign rt = c_time[gi+1];
        assign rk = c_kind[gi+1];
        assign rg = c_tgt[gi+1];
      end

      tepq_cell #(
        .TIME_BITS (TIME_BITS),
        .TGT_BITS  (TGT_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .op_i         (op),
        .valid_i      (CNT_W'(gi) < count_q),
        .new_time_i   (req_i.event_time),
        .new_kind_i   (req_i.event_kind),
        .new_tgt_i    (req_i.target_index),
        .left_place_i (lp),
        .left_time_i  (lt),
        .left_kind_i  (lk),
        .left_tgt_i   (lg),
        .right_time_i (rt),
        .right_kind_i (rk),
        .right_tgt_i  (rg),
        .place_o      (place[gi]),
        .time_o       (c_time[gi]),
        .kind_o       (c_kind[gi]),
        .tgt_o        (c_tgt[gi])
      );
    end
  endgenerate

  always_comb begin
    count_d  = count_q;
    status_d = ST_INSERTED;
    time_d   = '0;
    kind_d   = 1'b0;
    tgt_d    = '0;
    case (req_i.opcode)
      OP_INSERT: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_EXTRACT: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d = ST_EXTRACTED;
          time_d   = c_time[0];
          kind_d   = c_kind[0];
          tgt_d    = c_tgt[0];
          count_d  = count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_INSERTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      time_q   <= time_d;
      kind_q   <= kind_d;
      tgt_q    <= tgt_d;
      occ_q    <= count_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.out_time   = time_q;
  assign rsp_o.out_kind   = kind_q;
  assign rsp_o.out_target = tgt_q;
  assign rsp_o.occupancy  = occ_q;

endmodule

// ===== design/tepq_cell.sv =====
// ----------------------------------------------------------------------------
// tepq_cell
// One slot of the sorted row: holds an event, compares it against the
// broadcast event and takes data from itself, its neighbors or the broadcast.
// ----------------------------------------------------------------------------
module tepq_cell #(
  parameter int TIME_BITS = 31,
  parameter int TGT_BITS  = 4
) (
  input  logic                 clk_i,
  input  tepq_pkg::cell_op_t   op_i,
  input  logic                 valid_i,       // slot lies below the fill count
  input  logic [TIME_BITS-1:0] new_time_i,
  input  logic                 new_kind_i,
  input  logic [TGT_BITS-1:0]  new_tgt_i,
  input  logic                 left_place_i,  // left neighbor moves right
  input  logic [TIME_BITS-1:0] left_time_i,
  input  logic                 left_kind_i,
  input  logic [TGT_BITS-1:0]  left_tgt_i,
  input  logic [TIME_BITS-1:0] right_time_i,
  input  logic                 right_kind_i,
  input  logic [TGT_BITS-1:0]  right_tgt_i,
  output logic                 place_o,
  output logic [TIME_BITS-1:0] time_o,
  output logic                 kind_o,
  output logic [TGT_BITS-1:0]  tgt_o
);
  import tepq_pkg::*;

  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 kind_q, kind_d;
  logic [TGT_BITS-1:0]  tgt_q,  tgt_d;

  // strict compare keeps equal times in arrival order
  assign place_o = !valid_i || (time_q > new_time_i);

  always_comb begin
    time_d = time_q;
    kind_d = kind_q;
    tgt_d  = tgt_q;
    if (op_i.ext) begin
      time_d = right_time_i;
      kind_d = right_kind_i;
      tgt_d  = right_tgt_i;
    end else if (op_i.ins) begin
      if (left_place_i) begin
        time_d = left_time_i;
        kind_d = left_kind_i;
        tgt_d  = left_tgt_i;
      end else if (place_o) begin
        time_d = new_time_i;
        kind_d = new_kind_i;
        tgt_d  = new_tgt_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    kind_q <= kind_d;
    tgt_q  <= tgt_d;
  end

  assign time_o = time_q;
  assign kind_o = kind_q;
  assign tgt_o  = tgt_q;

endmodule

// ===== tb/tb_timed_event_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_timed_event_priority_queue_unit
// Self-checking bench for the timed event queue. A short table of directed
// operations comes first, followed by random fill / mixed / drain bursts
// under three idle profiles. A sorted shadow queue predicts each response not
// pinned by a directed row, and each response is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_timed_event_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tepq_pkg::*;

  localparam int QDEPTH      = 64;
  localparam int TBITS       = 31;
  localparam int PHASE_ITEMS = 610;
  localparam int BURST_LEN   = 96;
  localparam int HOLD_LEN    = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DIR_ROWS    = 20;
  localparam logic [TBITS-1:0] TMAX = '1;

  typedef struct packed {
    logic [TBITS-1:0] tstamp;
    logic             kind;
    logic [3:0]       tgt;
  } event_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TBITS-1:0] tstamp;
    logic             kind;
    logic [3:0]       tgt;
    logic [6:0]       occ;
  } rsp_t;

  typedef struct packed {
    logic   op;
    event_t ev;
    logic   pinned;
    rsp_t   want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tepq_req_if #(.TIME_BITS(TBITS), .TGT_BITS(4)) req_if ();
  tepq_rsp_if #(.TIME_BITS(TBITS), .TGT_BITS(4), .OCC_BITS(7)) rsp_if ();

  timed_event_priority_queue_unit #(
    .DEPTH       (QDEPTH),
    .TIME_BITS   (TBITS),
    .TARGET_COUNT(16)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  event_t sched_q[$];     // shadow of the sorted cell row
  rsp_t   expected_q[$];  // responses still owed by the block
  int     err_cnt;
  int     stall_cycles;
  int     tx_idle_pct;
  int     rx_idle_pct;
  bit     hold_pending;
  logic   cur_pinned;
  rsp_t   cur_pin_val;

  // Directed rows; pinned rows carry a hand-written response.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b1, '{ST_EMPTY, 31'd0, 1'b0, 4'd0, 7'd0}},
    '{OP_INSERT,  '{TMAX, 1'b1, 4'd15}, 1'b1, '{ST_INSERTED, 31'd0, 1'b0, 4'd0, 7'd1}},
    '{OP_INSERT,  '{31'd0, 1'b0, 4'd0}, 1'b1, '{ST_INSERTED, 31'd0, 1'b0, 4'd0, 7'd2}},
    '{OP_INSERT,  '{31'd100, 1'b1, 4'd5}, 1'b0, '0},
    '{OP_INSERT,  '{31'd100, 1'b0, 4'd6}, 1'b0, '0},
    '{OP_INSERT,  '{31'd100, 1'b1, 4'd7}, 1'b0, '0},
    '{OP_INSERT,  '{31'h2AAA_AAAA, 1'b0, 4'hA}, 1'b0, '0},
    '{OP_INSERT,  '{31'h5555_5555, 1'b1, 4'h5}, 1'b0, '0},
    '{OP_EXTRACT, '{TMAX, 1'b1, 4'hF}, 1'b1, '{ST_EXTRACTED, 31'd0, 1'b0, 4'd0, 7'd6}},
    '{OP_INSERT,  '{31'd100, 1'b0, 4'd9}, 1'b0, '0},
    '{OP_INSERT,  '{31'd0, 1'b1, 4'd3}, 1'b0, '0},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b1, '{ST_EXTRACTED, 31'd0, 1'b1, 4'd3, 7'd7}},
    '{OP_EXTRACT, '{31'h5555_5555, 1'b0, 4'h5}, 1'b0, '0},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b0, '0},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b0, '0},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b0, '0},
    '{OP_EXTRACT, '{31'h2AAA_AAAA, 1'b1, 4'hA}, 1'b0, '0},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b0, '0},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b1, '{ST_EXTRACTED, TMAX, 1'b1, 4'd15, 7'd0}},
    '{OP_EXTRACT, '{31'd0, 1'b0, 4'd0}, 1'b1, '{ST_EMPTY, 31'd0, 1'b0, 4'd0, 7'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stable sorted insert / head extract on the shadow row.
  function automatic rsp_t queue_op(input logic op, input event_t ev);
    rsp_t r;
    int   pos;
    r   = '0;
    pos = 0;
    if (op == OP_INSERT) begin
      if (sched_q.size() >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        while (pos < sched_q.size() && sched_q[pos].tstamp <= ev.tstamp) pos++;
        sched_q.insert(pos, ev);
        r.status = ST_INSERTED;
      end
    end else if (sched_q.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_EXTRACTED;
      r.tstamp = sched_q[0].tstamp;
      r.kind   = sched_q[0].kind;
      r.tgt    = sched_q[0].tgt;
      void'(sched_q.pop_front());
    end
    r.occ = 7'(sched_q.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Monitor: responses are checked before this edge's request is predicted.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t pred;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", {30'd0, rsp_if.status}, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", {30'd0, rsp_if.status}, {30'd0, want.status});
          if (rsp_if.out_time !== want.tstamp)
            report_mismatch("out_time", {1'b0, rsp_if.out_time}, {1'b0, want.tstamp});
          if (rsp_if.out_kind !== want.kind)
            report_mismatch("out_kind", {31'd0, rsp_if.out_kind}, {31'd0, want.kind});
          if (rsp_if.out_target !== want.tgt)
            report_mismatch("out_target", {28'd0, rsp_if.out_target}, {28'd0, want.tgt});
          if (rsp_if.occupancy !== want.occ)
            report_mismatch("occupancy", {25'd0, rsp_if.occupancy}, {25'd0, want.occ});
        end
      end
      if (req_if.valid && req_if.ready) begin
        pred = queue_op(req_if.opcode,
                        '{req_if.event_time, req_if.event_kind, req_if.target_index});
        expected_q.push_back(cur_pinned ? cur_pin_val : pred);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
    $display("[timed_event_priority_queue_unit] ERROR");
    $finish;
  end

  // Response side: random backpressure, or a long hold-off on request.
  initial begin
    int hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_op(input logic op, input event_t ev, input logic pin,
                         input rsp_t pin_val);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.event_time   <= ev.tstamp;
    req_if.event_kind   <= ev.kind;
    req_if.target_index <= ev.tgt;
    cur_pinned  = pin;
    cur_pin_val = pin_val;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Small times dominate so that equal timestamps are common.
  function automatic event_t rand_event();
    event_t ev;
    ev.kind = 1'($urandom_range(1));
    ev.tgt  = 4'($urandom_range(15));
    case ($urandom_range(9))
      0, 1, 2, 3: ev.tstamp = 31'($urandom_range(15));
      4:          ev.tstamp = '0;
      5:          ev.tstamp = TMAX;
      default:    ev.tstamp = 31'($urandom());
    endcase
    return ev;
  endfunction

  initial begin
    logic op;
    int   ins_pct;
    err_cnt             = 0;
    stall_cycles        = 0;
    hold_pending        = 1'b0;
    cur_pinned          = 1'b0;
    cur_pin_val         = '0;
    tx_idle_pct         = 37;
    rx_idle_pct         = 62;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_INSERT;
    req_if.event_time   = '0;
    req_if.event_kind   = 1'b0;
    req_if.target_index = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_op(dir_tab[i].op, dir_tab[i].ev, dir_tab[i].pinned, dir_tab[i].want);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 62 : 0;
      rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 37 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bursts cycle fill -> mixed -> drain so full and empty both occur
        case ((n / BURST_LEN) % 3)
          0:       ins_pct = 90;
          1:       ins_pct = 50;
          default: ins_pct = 10;
        endcase
        if (ph == 0 && n == 200) hold_pending = 1'b1;
        if (ph == 1 && n == 300) wait_drained();
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
        send_op(op, rand_event(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("[timed_event_priority_queue_unit] OK");
    else
      $display("[timed_event_priority_queue_unit] ERROR");
    $finish;
  end

endmodule
